>>> design/awfp_pkg.sv
package awfp_pkg;

    localparam int BYTE_W        = 8;
    localparam int WEIGHT_W      = 32;
    localparam int POS_W         = 3;
    localparam int DIGIT_W       = 4;
    localparam int FRACTION_LIMIT_DEF = 4;

    localparam logic [BYTE_W-1:0] ASCII_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] ASCII_NINE  = 8'h39;
    localparam logic [BYTE_W-1:0] ASCII_POINT = 8'h2E;

    // result of examining one byte against the current number state
    typedef struct packed {
        logic                term;
        logic [WEIGHT_W-1:0] acc;
        logic [POS_W-1:0]    pos;
        logic [WEIGHT_W-1:0] weight;
    } t_step;

    // ten to the power of the missing fraction digits
    function automatic logic [WEIGHT_W-1:0] pad_of(input logic [POS_W-1:0] e);
        logic [WEIGHT_W-1:0] p;
        case (e)
            3'd0:    p = 32'd1;
            3'd1:    p = 32'd10;
            3'd2:    p = 32'd100;
            3'd3:    p = 32'd1000;
            3'd4:    p = 32'd10000;
            3'd5:    p = 32'd100000;
            3'd6:    p = 32'd1000000;
            3'd7:    p = 32'd10000000;
            default: p = 32'd1;
        endcase
        return p;
    endfunction

endpackage

>>> design/awfp_rx_if.sv
interface awfp_rx_if import awfp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

>>> design/awfp_weight_if.sv
interface awfp_weight_if import awfp_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [WEIGHT_W-1:0] weight;

    modport source (output valid, output weight, input ready);
    modport sink   (input valid, input weight, output ready);
endinterface

>>> design/awfp_step.sv
module awfp_step import awfp_pkg::*; #(
    parameter int FRACTION_LIMIT = FRACTION_LIMIT_DEF
) (
    input  logic [BYTE_W-1:0]   i_byte,
    input  logic [WEIGHT_W-1:0] i_acc,
    input  logic [POS_W-1:0]    i_pos,
    output t_step               o_step
);

    localparam logic [POS_W-1:0] LIMIT = POS_W'(FRACTION_LIMIT);

    logic                  is_digit;
    logic                  take_digit;
    logic [DIGIT_W-1:0]    dval;
    logic [WEIGHT_W-1:0]   acc10;
    logic [POS_W-1:0]      pad_exp;
    logic [WEIGHT_W-1:0]   prod;
    logic [BYTE_W-1:0]     doff;

    assign is_digit   = (i_byte >= ASCII_ZERO) && (i_byte <= ASCII_NINE);
    assign take_digit = is_digit && (i_pos < LIMIT);
    assign doff       = i_byte - ASCII_ZERO;
    assign dval       = doff[DIGIT_W-1:0];
    // times ten as two shifts and an add
    assign acc10      = (i_acc << 3) + (i_acc << 1);
    // position never runs past the limit, so this stays in range
    assign pad_exp    = LIMIT - i_pos;
    // only the low word is kept, which wraps as the weight must
    assign prod       = i_acc * pad_of(pad_exp);

    always_comb begin
        o_step.term   = 1'b0;
        o_step.acc    = i_acc;
        o_step.pos    = i_pos;
        o_step.weight = prod;
        if (take_digit) begin
            o_step.acc = acc10 + WEIGHT_W'(dval);
            if (i_pos != '0) begin
                o_step.pos = i_pos + POS_W'(1);
            end
        end else if (i_byte == ASCII_POINT) begin
            o_step.pos = POS_W'(1);
        end else begin
            o_step.term = 1'b1;
            o_step.acc  = '0;
            o_step.pos  = '0;
        end
    end

endmodule

>>> design/ascii_weight_fixed_point_parser.sv
// ASCII weight parser: turns the byte stream of a weighing scale link into
// fixed-point weights scaled 10^FRACTION_LIMIT, or 10^(FRACTION_LIMIT-1) after a point.
// i_rx carries one received byte per request; digits build the number, a
// point starts the fraction and any other byte (or a digit past the last
// fraction place) ends it. o_weight carries one scaled weight per ended
// number; digits and points produce nothing on o_weight.
// Throughput: one byte per cycle, except that a terminator waits while the
// result register holds an untaken weight; the rate is set by the single
// pass of decode, times-ten add and pad multiply between the input register
// and the number state / result register.
// A terminating byte sits in the input register, then loads the result
// register once that is free, and its weight shows on o_weight from there.
// Reset clears the number state and both valid flags; no memory to clear.
// When the receiver stalls, the result register holds its weight and the
// block keeps taking digits and points; a second terminator waits in the
// input register, and i_rx.ready drops only then.
module ascii_weight_fixed_point_parser import awfp_pkg::*; #(
    parameter int FRACTION_LIMIT = FRACTION_LIMIT_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    awfp_rx_if.sink       i_rx,
    awfp_weight_if.source o_weight
);

    logic                r_in_valid;
    logic [BYTE_W-1:0]   r_in_byte;
    logic [WEIGHT_W-1:0] r_acc;
    logic [POS_W-1:0]    r_pos;
    logic                r_out_valid;
    logic [WEIGHT_W-1:0] r_out_weight;

    t_step n_step;
    logic  out_free;
    logic  advance;
    logic  load_out;

    awfp_step #(
        .FRACTION_LIMIT(FRACTION_LIMIT)
    ) u_step (
        .i_byte (r_in_byte),
        .i_acc  (r_acc),
        .i_pos  (r_pos),
        .o_step (n_step)
    );

    assign out_free = !r_out_valid || o_weight.ready;
    assign advance  = r_in_valid && (!n_step.term || out_free);
    assign load_out = advance && n_step.term;

    assign i_rx.ready      = !r_in_valid || advance;
    assign o_weight.valid  = r_out_valid;
    assign o_weight.weight = r_out_weight;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_acc       <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_rx.ready) begin
                r_in_valid <= i_rx.valid;
            end
            if (advance) begin
                r_acc <= n_step.acc;
                r_pos <= n_step.pos;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_weight.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
        end
        if (load_out) begin
            r_out_weight <= n_step.weight;
        end
    end

`ifndef SYNTHESIS
    // the fraction position never passes the last fraction place
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_W'(FRACTION_LIMIT))
        else $error("fraction position beyond limit");

    // a finished number leaves the state cleared for the next one
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |=> (r_acc == '0) && (r_pos == '0) && r_out_valid)
        else $error("state not cleared after result");

    // a new weight never overwrites one the receiver has not taken
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |-> (!r_out_valid || o_weight.ready))
        else $error("pending weight overwritten");
`endif

endmodule
